// ===== rtl/srw_pkg.sv =====
// Shared constants, types and modular helpers for the selective-repeat window engine.
package srw_pkg;

  localparam int SEQ_SPACE = 16;
  localparam int WINDOW    = 8;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int TXW       = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;
  localparam int RXW       = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE;
  localparam int RUN_W     = $clog2(RXW + 1);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [SEQ_W:0]   dist_t;
  typedef logic [RUN_W-1:0] run_t;

  localparam dist_t TXW_D  = dist_t'(TXW);
  localparam dist_t RXW_D  = dist_t'(RXW);
  localparam run_t  RXW_R  = run_t'(RXW);
  localparam seq_t  SEQ_TOP = seq_t'(SEQ_SPACE - 1);

  // Request kinds
  localparam logic [1:0] REQ_APP  = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_TMO  = 2'd3;

  // Result actions
  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_DELIVER = 3'd2;
  localparam logic [2:0] ACT_FULL    = 3'd3;
  localparam logic [2:0] ACT_ACCEPT  = 3'd4;
  localparam logic [2:0] ACT_IGNORE  = 3'd5;

  // Port of one mark memory
  typedef struct packed {
    logic wr_en;
    seq_t wr_addr;
    logic wr_data;
    seq_t rd_addr;
  } mark_req_t;

  // Modular distance a - b over the sequence space
  function automatic dist_t seq_dist(seq_t a, seq_t b);
    dist_t d;
    if (a >= b) begin
      d = dist_t'(a) - dist_t'(b);
    end else begin
      d = dist_t'(a) + dist_t'(SEQ_SPACE) - dist_t'(b);
    end
    return d;
  endfunction

  function automatic seq_t seq_inc(seq_t a);
    seq_t r;
    if (a == SEQ_TOP) begin
      r = '0;
    end else begin
      r = a + seq_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/srw_mark_mem.sv =====
// One-bit-wide mark memory, one write and one registered read per cycle.
module srw_mark_mem (
  input  logic              clk,
  input  srw_pkg::mark_req_t req,
  output logic              rd_data
);
  import srw_pkg::*;

  logic mem [SEQ_SPACE];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/selective_repeat_window_engine_core.sv =====
// Selective-repeat window engine: sequencer over the ack and receive mark memories.
//
//  channel   ports                                             transfer when
//  -------   -----------------------------------------------   ---------------------
//  input     start, busy, in_req_type, in_seq_number            start && !busy
//  result    out_valid, out_action, out_seq, out_start_timer,   out_valid (one cycle)
//            out_stop_timer, out_last
//
// An app packet, a timeout, a stray ack or data that is not marked is answered
// from the check state, which then returns to idle. An accepted ack goes on through
// the read and walk states and slides one mark per walk step; marked data walks the
// same way and delivers one number per step. The walks are set by the one read
// port of each mark memory. After reset the block sweeps both memories clear
// with busy high. Results are never held off; each shows for exactly one cycle.
module selective_repeat_window_engine_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [3:0]       in_seq_number,
  output logic             out_valid,
  output logic [2:0]       out_action,
  output logic [3:0]       out_seq,
  output logic             out_start_timer,
  output logic             out_stop_timer,
  output logic             out_last
);
  import srw_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_WCHK = 3'd4;

  logic [2:0] state_r, state_nxt;
  seq_t       clr_r, clr_nxt;
  seq_t       tx_base_r, tx_base_nxt;
  seq_t       tx_next_r, tx_next_nxt;
  seq_t       rx_base_r, rx_base_nxt;
  logic [1:0] req_r, req_nxt;
  seq_t       seq_r, seq_nxt;
  run_t       run_r, run_nxt;

  logic       ov_r, ov_nxt;
  logic [2:0] act_r, act_nxt;
  seq_t       oseq_r, oseq_nxt;
  logic       st_r, st_nxt;
  logic       ct_r, ct_nxt;
  logic       last_r, last_nxt;

  mark_req_t  ack_req, rcv_req;
  logic       ack_rd, rcv_rd;
  dist_t      outstanding;
  logic       tx_hit;
  logic       rx_hit;

  srw_mark_mem u_ack_mem (.clk(clk), .req(ack_req), .rd_data(ack_rd));
  srw_mark_mem u_rcv_mem (.clk(clk), .req(rcv_req), .rd_data(rcv_rd));

  assign outstanding = seq_dist(tx_next_r, tx_base_r);
  assign tx_hit = (seq_dist(seq_r, tx_base_r) < outstanding) && !ack_rd;
  assign rx_hit = (seq_dist(seq_r, rx_base_r) < RXW_D) && !rcv_rd;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    tx_base_nxt = tx_base_r;
    tx_next_nxt = tx_next_r;
    rx_base_nxt = rx_base_r;
    req_nxt     = req_r;
    seq_nxt     = seq_r;
    run_nxt     = run_r;
    ov_nxt      = 1'b0;
    act_nxt     = act_r;
    oseq_nxt    = oseq_r;
    st_nxt      = 1'b0;
    ct_nxt      = 1'b0;
    last_nxt    = 1'b0;
    ack_req     = '{wr_en: 1'b0, wr_addr: seq_r, wr_data: 1'b0,
                    rd_addr: in_seq_number[SEQ_W-1:0]};
    rcv_req     = ack_req;

    case (state_r)
      S_CLR: begin
        ack_req.wr_en   = 1'b1;
        ack_req.wr_addr = clr_r;
        rcv_req.wr_en   = 1'b1;
        rcv_req.wr_addr = clr_r;
        clr_nxt         = seq_inc(clr_r);
        if (clr_r == SEQ_TOP) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          seq_nxt   = in_seq_number[SEQ_W-1:0];
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        ov_nxt    = 1'b1;
        last_nxt  = 1'b1;
        oseq_nxt  = seq_r;
        state_nxt = S_IDLE;
        case (req_r)
          REQ_APP: begin
            oseq_nxt = tx_next_r;
            if (outstanding < TXW_D) begin
              ack_req.wr_en   = 1'b1;
              ack_req.wr_addr = tx_next_r;
              act_nxt         = ACT_SEND;
              st_nxt          = 1'b1;
              tx_next_nxt     = seq_inc(tx_next_r);
            end else begin
              act_nxt = ACT_FULL;
            end
          end
          REQ_ACK: begin
            if (tx_hit) begin
              ack_req.wr_en   = 1'b1;
              ack_req.wr_data = 1'b1;
              act_nxt         = ACT_ACCEPT;
              ct_nxt          = 1'b1;
              state_nxt       = S_WRD;
            end else begin
              act_nxt = ACT_IGNORE;
            end
          end
          REQ_DATA: begin
            if (rx_hit) begin
              // Mark now, report once the in-order run is walked
              rcv_req.wr_en   = 1'b1;
              rcv_req.wr_data = 1'b1;
              ov_nxt          = 1'b0;
              last_nxt        = 1'b0;
              run_nxt         = '0;
              state_nxt       = S_WRD;
            end else begin
              act_nxt = ACT_ACK;
            end
          end
          default: begin
            if (tx_hit) begin
              act_nxt = ACT_SEND;
              st_nxt  = 1'b1;
            end else begin
              act_nxt = ACT_IGNORE;
            end
          end
        endcase
      end
      S_WRD: begin
        ack_req.rd_addr = tx_base_r;
        rcv_req.rd_addr = rx_base_r;
        state_nxt       = S_WCHK;
      end
      S_WCHK: begin
        if (req_r == REQ_ACK) begin
          // Slide the transmit base over acked numbers
          if ((tx_base_r != tx_next_r) && ack_rd) begin
            ack_req.wr_en   = 1'b1;
            ack_req.wr_addr = tx_base_r;
            ack_req.rd_addr = seq_inc(tx_base_r);
            tx_base_nxt     = seq_inc(tx_base_r);
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          ov_nxt = 1'b1;
          if ((run_r < RXW_R) && rcv_rd) begin
            rcv_req.wr_en   = 1'b1;
            rcv_req.wr_addr = rx_base_r;
            rcv_req.rd_addr = seq_inc(rx_base_r);
            act_nxt         = ACT_DELIVER;
            oseq_nxt        = rx_base_r;
            rx_base_nxt     = seq_inc(rx_base_r);
            run_nxt         = run_r + run_t'(1);
          end else begin
            act_nxt   = ACT_ACK;
            oseq_nxt  = seq_r;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      tx_base_r <= '0;
      tx_next_r <= '0;
      rx_base_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      tx_base_r <= tx_base_nxt;
      tx_next_r <= tx_next_nxt;
      rx_base_r <= rx_base_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    seq_r  <= seq_nxt;
    run_r  <= run_nxt;
    act_r  <= act_nxt;
    oseq_r <= oseq_nxt;
    st_r   <= st_nxt;
    ct_r   <= ct_nxt;
    last_r <= last_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_action       = act_r;
  assign out_seq          = 4'(oseq_r);
  assign out_start_timer  = st_r;
  assign out_stop_timer   = ct_r;
  assign out_last         = last_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the selective-repeat window engine core.
`timescale 1ns / 100ps

module tb_top;
  import srw_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_ITEMS    = 89;

  typedef struct packed {
    logic [2:0] action;
    seq_t       seq;
    logic       start_timer;
    logic       stop_timer;
    logic       last;
  } arq_result_t;

  // Window bookkeeping mirror plus the queue of results still owed by the block
  class window_book;
    seq_t        tx_base;
    seq_t        tx_next;
    seq_t        rx_base;
    seq_t        rx_limit;
    bit          acked [SEQ_SPACE];
    bit          received [SEQ_SPACE];
    arq_result_t due_results [$];
    int          fails;

    function new();
      tx_base  = '0;
      tx_next  = '0;
      rx_base  = '0;
      rx_limit = seq_t'(WINDOW % SEQ_SPACE);
      foreach (acked[i]) begin
        acked[i]    = 1'b0;
        received[i] = 1'b0;
      end
      fails = 0;
    endfunction

    function seq_t wrap_add(seq_t a, int n);
      return seq_t'((int'(a) + n) % SEQ_SPACE);
    endfunction

    function int gap(seq_t a, seq_t b);
      return (int'(a) + SEQ_SPACE - int'(b)) % SEQ_SPACE;
    endfunction

    function int in_flight();
      return gap(tx_next, tx_base);
    endfunction

    function void owe(logic [2:0] act, seq_t s, logic st, logic ct);
      arq_result_t r;
      r.action      = act;
      r.seq         = s;
      r.start_timer = st;
      r.stop_timer  = ct;
      r.last        = 1'b0;
      due_results.push_back(r);
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] seq_in);
      seq_t s;
      int   k;
      s = seq_t'(int'(seq_in) % SEQ_SPACE);
      case (req)
        REQ_APP: begin
          if (in_flight() < TXW) begin
            acked[tx_next] = 1'b0;
            owe(ACT_SEND, tx_next, 1'b1, 1'b0);
            tx_next = wrap_add(tx_next, 1);
          end else begin
            owe(ACT_FULL, tx_next, 1'b0, 1'b0);
          end
        end
        REQ_ACK: begin
          if (gap(s, tx_base) < in_flight() && !acked[s]) begin
            acked[s] = 1'b1;
            owe(ACT_ACCEPT, s, 1'b0, 1'b1);
            // slide the base past every acknowledged number, clearing marks
            while (tx_base != tx_next && acked[tx_base]) begin
              acked[tx_base] = 1'b0;
              tx_base = wrap_add(tx_base, 1);
            end
          end else begin
            owe(ACT_IGNORE, s, 1'b0, 1'b0);
          end
        end
        REQ_DATA: begin
          if (gap(s, rx_base) < RXW && !received[s]) begin
            received[s] = 1'b1;
            k = 0;
            while (k < RXW && received[rx_base]) begin
              owe(ACT_DELIVER, rx_base, 1'b0, 1'b0);
              received[rx_base] = 1'b0;
              rx_base  = wrap_add(rx_base, 1);
              rx_limit = wrap_add(rx_limit, 1);
              k++;
            end
          end
          owe(ACT_ACK, s, 1'b0, 1'b0);
        end
        default: begin
          if (gap(s, tx_base) < in_flight() && !acked[s]) begin
            owe(ACT_SEND, s, 1'b1, 1'b0);
          end else begin
            owe(ACT_IGNORE, s, 1'b0, 1'b0);
          end
        end
      endcase
      due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [2:0] act, seq_t s, logic st, logic ct, logic lst);
      arq_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: out_action %0d out_seq %0d", act, s);
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (act !== want.action) begin
        $error("out_action: expected %0d, actual %0d", want.action, act);
        fails++;
      end
      if (s !== want.seq) begin
        $error("out_seq: expected %0d, actual %0d", want.seq, s);
        fails++;
      end
      if (st !== want.start_timer) begin
        $error("out_start_timer: expected %0d, actual %0d", want.start_timer, st);
        fails++;
      end
      if (ct !== want.stop_timer) begin
        $error("out_stop_timer: expected %0d, actual %0d", want.stop_timer, ct);
        fails++;
      end
      if (lst !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, lst);
        fails++;
      end
    endfunction
  endclass

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       start         = 1'b0;
  logic [1:0] in_req_type   = '0;
  logic [3:0] in_seq_number = '0;
  logic       busy;
  logic       out_valid;
  logic [2:0] out_action;
  logic [3:0] out_seq;
  logic       out_start_timer;
  logic       out_stop_timer;
  logic       out_last;

  window_book book = new();
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  selective_repeat_window_engine_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_seq_number    (in_seq_number),
    .out_valid        (out_valid),
    .out_action       (out_action),
    .out_seq          (out_seq),
    .out_start_timer  (out_start_timer),
    .out_stop_timer   (out_stop_timer),
    .out_last         (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      book.check_result(out_action, out_seq, out_start_timer, out_stop_timer, out_last);
    end
  end

  // Reset the count on any transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold the request until the edge that transfers it; start stays high on return
  task automatic send_request(input logic [1:0] req, input logic [3:0] s);
    in_req_type   <= req;
    in_seq_number <= s;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    book.note_request(req, s);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (book.due_results.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic aimed at the live windows, with some noise
  task automatic random_request(input int idle_pct);
    logic [1:0] req;
    logic [3:0] s;
    int         pick;
    int         span;
    pick = $urandom_range(99);
    span = book.in_flight();
    s    = 4'($urandom_range(15));
    if (pick < 30) begin
      req = REQ_APP;
    end else if (pick < 55) begin
      req = REQ_ACK;
      if (span > 0 && $urandom_range(99) < 80) begin
        s = book.wrap_add(book.tx_base, int'($urandom_range(span - 1)));
      end
    end else if (pick < 85) begin
      req = REQ_DATA;
      if ($urandom_range(99) < 85) begin
        s = book.wrap_add(book.rx_base, int'($urandom_range(RXW - 1)));
      end
    end else begin
      req = REQ_TMO;
      if (span > 0 && $urandom_range(99) < 75) begin
        s = book.wrap_add(book.tx_base, int'($urandom_range(span - 1)));
      end
    end
    send_request(req, s);
    if (int'($urandom_range(99)) < idle_pct) begin
      hold_off($urandom_range(1, 8));
    end
  endtask

  initial begin
    int         idle_mix [4] = '{0, 66, 0, 34};
    logic [5:0] plan [$] = '{
      {REQ_TMO, 4'd0},  {REQ_ACK, 4'd15},
      {REQ_APP, 4'd0},  {REQ_APP, 4'd15}, {REQ_APP, 4'd5},  {REQ_APP, 4'd10},
      {REQ_APP, 4'd3},  {REQ_APP, 4'd12}, {REQ_APP, 4'd6},  {REQ_APP, 4'd9},
      {REQ_APP, 4'd0},
      {REQ_ACK, 4'd3},  {REQ_ACK, 4'd3},  {REQ_TMO, 4'd3},  {REQ_TMO, 4'd5},
      {REQ_ACK, 4'd0},
      {REQ_DATA, 4'd1}, {REQ_DATA, 4'd2}, {REQ_DATA, 4'd2}, {REQ_DATA, 4'd3},
      {REQ_DATA, 4'd4}, {REQ_DATA, 4'd5}, {REQ_DATA, 4'd6}, {REQ_DATA, 4'd7},
      {REQ_DATA, 4'd0}, {REQ_DATA, 4'd3}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      send_request(plan[i][5:4], plan[i][3:0]);
    end
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      repeat (PHASE_ITEMS) random_request(idle_mix[phase]);
      drain_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.fails == 0 && book.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
